>>> design/ihb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the IPv4 header builder.
package ihb_pkg;

    // Header geometry
    localparam int          HDR_BYTES = 20;
    localparam int          IDX_W     = 5;
    localparam logic [4:0]  LAST_IDX  = 5'(HDR_BYTES - 1);

    // Fixed header contents
    localparam logic [7:0]  VER_IHL   = 8'h45;
    localparam logic [15:0] ID_START  = 16'h1200;
    localparam logic [15:0] ID_LIMIT  = 16'hFFFF;
    localparam logic [7:0]  TTL_RESET = 8'd64;

    // Protocol numbers
    localparam logic [7:0]  PROTO_UDP  = 8'h11;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;
    localparam logic [7:0]  PROTO_ICMP = 8'h01;
    localparam logic [7:0]  PROTO_NONE = 8'h00;

    // Protocol kind codes on the request
    localparam logic [1:0]  KIND_UDP  = 2'd0;
    localparam logic [1:0]  KIND_TCP  = 2'd1;
    localparam logic [1:0]  KIND_ICMP = 2'd2;

    // Command codes
    localparam logic        CMD_NORMAL = 1'b0;
    localparam logic        CMD_PING   = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 1;
    localparam logic        CFG_TTL      = 1'b0;
    localparam logic        CFG_LOCAL_IP = 1'b1;

    // Header fields that vary per packet
    typedef struct packed {
        logic [15:0] length;
        logic [15:0] ident;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] local_ip;
        logic [31:0] remote_ip;
    } t_hdr_fields;

    // Complete header description handed to the serializer
    typedef struct packed {
        t_hdr_fields f;
        logic [15:0] csum;
    } t_hdr_desc;

    // Queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Map a protocol kind to its protocol number
    function automatic logic [7:0] proto_code(input logic [1:0] kind);
        logic [7:0] code;
        unique case (kind)
            KIND_UDP:  code = PROTO_UDP;
            KIND_TCP:  code = PROTO_TCP;
            KIND_ICMP: code = PROTO_ICMP;
            default:   code = PROTO_NONE;
        endcase
        return code;
    endfunction

    // Select one header byte in wire order
    function automatic logic [7:0] hdr_byte(input t_hdr_desc d, input logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = VER_IHL;
            5'd2:    b = d.f.length[15:8];
            5'd3:    b = d.f.length[7:0];
            5'd4:    b = d.f.ident[15:8];
            5'd5:    b = d.f.ident[7:0];
            5'd8:    b = d.f.ttl;
            5'd9:    b = d.f.proto;
            5'd10:   b = d.csum[15:8];
            5'd11:   b = d.csum[7:0];
            5'd12:   b = d.f.local_ip[31:24];
            5'd13:   b = d.f.local_ip[23:16];
            5'd14:   b = d.f.local_ip[15:8];
            5'd15:   b = d.f.local_ip[7:0];
            5'd16:   b = d.f.remote_ip[31:24];
            5'd17:   b = d.f.remote_ip[23:16];
            5'd18:   b = d.f.remote_ip[15:8];
            5'd19:   b = d.f.remote_ip[7:0];
            default: b = 8'h00;  // TOS, flags and fragment offset
        endcase
        return b;
    endfunction

endpackage

>>> design/ihb_front.sv
`timescale 1ns / 1ps
// Request intake: identification counter and two-stage checksum pipeline.
module ihb_front
    import ihb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [1:0]  i_protocol_kind,
    input  logic [15:0] i_total_length,
    input  logic [31:0] i_remote_ip,
    input  logic [15:0] i_echo_id,
    // configuration values
    input  logic [7:0]  i_ttl,
    input  logic [31:0] i_local_ip,
    // toward the queue
    output logic        o_push,
    output t_hdr_desc   o_desc,
    input  t_q_stat     i_q_stat
);

    logic        r_a_valid;
    t_hdr_fields r_a;
    logic        r_b_valid;
    t_hdr_fields r_b;
    logic [17:0] r_s1;
    logic [17:0] r_s2;
    logic [15:0] r_id;

    logic        b_free;
    logic        a_free;
    logic        take;
    logic [15:0] id_inc;
    logic [15:0] n_id;
    logic [17:0] n_s1;
    logic [17:0] n_s2;
    logic [18:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // Stage stalls propagate back from the queue
    assign b_free  = !r_b_valid || !i_q_stat.full;
    assign a_free  = !r_a_valid || b_free;
    assign o_stall = !a_free;
    assign take    = i_valid && a_free;

    // Advance the identification counter, wrapping before the limit
    assign id_inc = r_id + 16'd1;
    assign n_id   = (id_inc == ID_LIMIT) ? ID_START : id_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= ID_START;
        end else if (take) begin
            r_id <= n_id;
        end
    end

    // Stage A: capture request fields and identification
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a.length    <= i_total_length;
            r_a.ident     <= (i_command == CMD_PING) ? i_echo_id : n_id;
            r_a.ttl       <= i_ttl;
            r_a.proto     <= proto_code(i_protocol_kind);
            r_a.local_ip  <= i_local_ip;
            r_a.remote_ip <= i_remote_ip;
        end
    end

    // Stage B: two partial sums of the header words
    assign n_s1 = 18'({VER_IHL, 8'h00}) + 18'(r_a.length) + 18'(r_a.ident)
                + 18'({r_a.ttl, r_a.proto});
    assign n_s2 = 18'(r_a.local_ip[31:16]) + 18'(r_a.local_ip[15:0])
                + 18'(r_a.remote_ip[31:16]) + 18'(r_a.remote_ip[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_valid) begin
            r_b  <= r_a;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    // Combine, fold the carries twice and complement
    assign sum   = 19'(r_s1) + 19'(r_s2);
    assign fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    assign o_push      = r_b_valid;
    assign o_desc.f    = r_b;
    assign o_desc.csum = ~fold2;

endmodule

>>> design/ihb_queue.sv
`timescale 1ns / 1ps
// Show-ahead descriptor queue between the intake and the serializer.
module ihb_queue
    import ihb_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_hdr_desc i_desc,
    input  logic      i_pop,
    output t_hdr_desc o_head,
    output t_q_stat   o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_hdr_desc        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> design/ihb_serializer.sv
`timescale 1ns / 1ps
// Header serializer: one byte per word from the queue head into the output register.
module ihb_serializer
    import ihb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // from the queue
    input  t_hdr_desc  i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_header_byte,
    output logic [4:0] o_byte_index,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic [4:0] r_index;
    logic       r_last;
    logic [4:0] r_idx;

    logic load;
    logic at_last;

    assign load    = !i_q_stat.empty && (!r_valid || !i_stall);
    assign at_last = (r_idx == LAST_IDX);
    assign o_pop   = load && at_last;

    // Hold, refill or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= at_last ? '0 : r_idx + 5'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= hdr_byte(i_head, r_idx);
            r_index <= r_idx;
            r_last  <= at_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_header_byte = r_byte;
    assign o_byte_index  = r_index;
    assign o_last        = r_last;

endmodule

>>> design/ipv4_header_builder_core.sv
`timescale 1ns / 1ps
// Top level of the IPv4 header builder: intake, descriptor queue, serializer.
//
//  channel   | direction | handshake          | words per packet
//  ----------+-----------+--------------------+------------------
//  request   | in        | i_valid / o_stall  | 1
//  header    | out       | o_valid / i_stall  | 20 bytes
//  config    | in        | i_cfg_we           | one register
//
// The serializer sends one header byte per cycle from its output register
// while not stalled, back to back across packets. A request passes two intake
// stages, the queue and the output register before its first byte appears.
// Requests are taken every cycle until the queue and both intake stages fill.
// Synchronous active-low reset clears the counter to 0x1200, TTL to 64, and
// the source address to zero; an output stall holds the current byte.
module ipv4_header_builder_core
    import ihb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic [1:0]           i_protocol_kind,
    input  logic [15:0]          i_total_length,
    input  logic [31:0]          i_remote_ip,
    input  logic [15:0]          i_echo_id,
    // header byte channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_header_byte,
    output logic [4:0]           o_byte_index,
    output logic                 o_last,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [7:0]  r_ttl;
    logic [31:0] r_local_ip;

    logic        push;
    logic        pop;
    t_hdr_desc   push_desc;
    t_hdr_desc   head;
    t_q_stat     q_stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl      <= TTL_RESET;
            r_local_ip <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TTL:      r_ttl      <= i_cfg_data[7:0];
                CFG_LOCAL_IP: r_local_ip <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    ihb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_protocol_kind (i_protocol_kind),
        .i_total_length  (i_total_length),
        .i_remote_ip     (i_remote_ip),
        .i_echo_id       (i_echo_id),
        .i_ttl           (r_ttl),
        .i_local_ip      (r_local_ip),
        .o_push          (push),
        .o_desc          (push_desc),
        .i_q_stat        (q_stat)
    );

    ihb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    ihb_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_header_byte (o_header_byte),
        .o_byte_index  (o_byte_index),
        .o_last        (o_last)
    );

    // The last flag marks exactly the final header byte
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_byte_index == LAST_IDX)))
        else $error("last flag and byte index disagree");

    // Once a byte inside a header is taken, the next one follows at once
    a_next_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last)
        |=> (o_valid && (o_byte_index == 5'($past(o_byte_index) + 5'd1))))
        else $error("header bytes not contiguous");

    // Every header opens with version and header length
    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_byte_index == 5'd0)) |-> (o_header_byte == VER_IHL))
        else $error("header does not start with version byte");

    // The queue is never reported full and empty together
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

endmodule
